### hw/rtl/gif_lzw_encoder_assert.svh
// ---------------------------------------------------------------------------
// GIF LZW encoder assertion macros
// Concurrent check forms used by the encoder's dictionary engine.
// ---------------------------------------------------------------------------
`ifndef GIF_LZW_ENCODER_ASSERT_SVH
`define GIF_LZW_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while the given reset is high.
`define GLE_CHECK(label, rst_sig, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("gle check failed");

// Next-cycle implication, disabled while the given reset is high.
`define GLE_CHECK_NEXT(label, rst_sig, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("gle next-cycle check failed");

`endif

### hw/rtl/gle_pkg.sv
// ---------------------------------------------------------------------------
// GIF LZW encoder package
// Sizes, handshake words, sequencer states and helpers of the encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package gle_pkg;

  localparam int TABLE_SIZE    = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int CODE_LIMIT    = (TABLE_SIZE < (1 << MAX_CODE_BITS)) ?
                                 TABLE_SIZE : (1 << MAX_CODE_BITS);
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int NEXT_W        = CODE_W + 1;
  localparam int PIX_W         = 8;
  localparam int ROOT_W        = 4;
  localparam int ROOT_MIN      = 2;
  localparam int ROOT_MAX      = 8;
  localparam int ROOT_RESET    = 2;
  localparam int ROOTS         = 1 << PIX_W;
  localparam int ACC_W         = 20;
  localparam int ACC_CNT_W     = 5;
  localparam int IN_DEPTH      = 4;
  localparam int OUT_DEPTH     = 8;

  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } pix_word_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [ROOT_W-1:0] width;
    logic              eoi;
  } code_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DISPATCH,
    S_CHILD,
    S_NODE,
    S_MISS,
    S_INS_A,
    S_INS_B,
    S_RESTART,
    S_TAIL,
    S_FIN_PREFIX,
    S_FIN_EOI
  } state_t;

  function automatic logic [ROOT_W-1:0] eff_root(input logic [ROOT_W-1:0] r);
    logic [ROOT_W-1:0] v;
    v = r;
    if (r < ROOT_W'(ROOT_MIN)) v = ROOT_W'(ROOT_MIN);
    if (r > ROOT_W'(ROOT_MAX)) v = ROOT_W'(ROOT_MAX);
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gle_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/gle_front.sv
// ---------------------------------------------------------------------------
// GIF LZW encoder front end
// Accepts pixel words, masks them to the root width and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module gle_front (
  input  wire logic                      clk,
  input  wire logic                      clr,
  input  wire logic [gle_pkg::ROOT_W-1:0] root,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [gle_pkg::PIX_W-1:0]  pixel,
  input  wire logic                      last_pixel,
  output gle_pkg::pix_word_t             word,
  input  wire logic                      take
);

  localparam int PW = $clog2(gle_pkg::IN_DEPTH);

  logic [gle_pkg::PIX_W:0] mem [gle_pkg::IN_DEPTH];
  logic [PW-1:0]           wp;
  logic [PW-1:0]           rp;
  logic [PW:0]             cnt;
  logic [gle_pkg::PIX_W-1:0] mask;
  logic                    wr;
  logic                    rd;

  assign mask = gle_pkg::PIX_W'({gle_pkg::PIX_W{1'b1}} >> (gle_pkg::ROOT_W'(gle_pkg::PIX_W) - root));
  assign full = (cnt == (PW+1)'(gle_pkg::IN_DEPTH));
  assign wr   = push && !full;
  assign rd   = take && (cnt != '0);

  assign word.valid = (cnt != '0);
  assign word.pixel = mem[rp][gle_pkg::PIX_W:1];
  assign word.last  = mem[rp][0];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= {pixel & mask, last_pixel};
    end
    if (clr) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gle_back.sv
// ---------------------------------------------------------------------------
// GIF LZW encoder dictionary engine
// Walks the code trie, inserts new strings and issues codes to the packer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gif_lzw_encoder_assert.svh"

module gle_back (
  input  wire logic                       clk,
  input  wire logic                       clr,
  input  wire logic [gle_pkg::ROOT_W-1:0] root,
  input  wire logic [gle_pkg::ROOT_W-1:0] root_load,
  input  gle_pkg::pix_word_t              in_word,
  output logic                            take,
  output gle_pkg::code_word_t             cw,
  input  wire logic                       code_ready
);

  localparam int CW = gle_pkg::CODE_W;
  localparam int NW = gle_pkg::NEXT_W;
  localparam int PX = gle_pkg::PIX_W;
  localparam int RW = gle_pkg::ROOT_W;

  gle_pkg::state_t state, state_next;

  logic [CW-1:0] cur, cur_next;
  logic          have_prefix, have_prefix_next;
  logic          started, started_next;
  logic [NW-1:0] next_code, next_code_next;
  logic [RW-1:0] width, width_next;
  logic [PX-1:0] p, p_next;
  logic          last, last_next;
  logic [CW-1:0] head, head_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [gle_pkg::ROOTS-1:0] root_wr;

  logic [NW-1:0] clear_code;
  logic [RW-1:0] grown;
  logic [CW-1:0] first;
  logic [CW-1:0] sib;
  logic [PX-1:0] pix;
  logic          set_wr;
  logic [CW-1:0] set_addr;
  logic          wr_clear;

  logic          child_we;
  logic [CW-1:0] child_wa, child_wd, child_ra, child_rd;
  logic          node_we;
  logic [CW-1:0] node_wa, node_ra;
  logic [PX+CW-1:0] node_wd, node_rd;

  gle_ram #(.WIDTH(CW), .DEPTH(gle_pkg::TABLE_SIZE)) u_child (
    .clk(clk), .we(child_we), .waddr(child_wa), .wdata(child_wd),
    .raddr(child_ra), .rdata(child_rd)
  );

  gle_ram #(.WIDTH(PX+CW), .DEPTH(gle_pkg::TABLE_SIZE)) u_node (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_rd)
  );

  assign clear_code = NW'(1) << root;
  assign grown = (width < RW'(gle_pkg::MAX_CODE_BITS) && next_code == (NW'(1) << width)) ?
                 width + 1'b1 : width;
  // A root code's child link counts only once written in this dictionary.
  assign first = (cur[CW-1:PX] == '0 && !root_wr[cur[PX-1:0]]) ? '0 : child_rd;
  assign sib   = node_rd[CW-1:0];
  assign pix   = node_rd[PX+CW-1:CW];

  always_ff @(posedge clk) begin
    if (clr) begin
      state       <= gle_pkg::S_IDLE;
      cur         <= '0;
      have_prefix <= 1'b0;
      started     <= 1'b0;
      next_code   <= (NW'(1) << root_load) + NW'(2);
      width       <= root_load + 1'b1;
      root_wr     <= '0;
    end else begin
      state       <= state_next;
      cur         <= cur_next;
      have_prefix <= have_prefix_next;
      started     <= started_next;
      next_code   <= next_code_next;
      width       <= width_next;
      if (wr_clear) begin
        root_wr <= '0;
      end else if (set_wr && set_addr[CW-1:PX] == '0) begin
        root_wr[set_addr[PX-1:0]] <= 1'b1;
      end
    end
    p    <= p_next;
    last <= last_next;
    head <= head_next;
    ptr  <= ptr_next;
  end

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    have_prefix_next = have_prefix;
    started_next     = started;
    next_code_next   = next_code;
    width_next       = width;
    p_next           = p;
    last_next        = last;
    head_next        = head;
    ptr_next         = ptr;
    take             = 1'b0;
    cw               = '0;
    child_we         = 1'b0;
    child_wa         = cur;
    child_wd         = next_code[CW-1:0];
    child_ra         = cur;
    node_we          = 1'b0;
    node_wa          = next_code[CW-1:0];
    node_wd          = {p, head};
    node_ra          = first;
    set_wr           = 1'b0;
    set_addr         = cur;
    wr_clear         = 1'b0;
    unique case (state)
      gle_pkg::S_IDLE: begin
        if (in_word.valid) begin
          take       = 1'b1;
          p_next     = in_word.pixel;
          last_next  = in_word.last;
          state_next = started ? gle_pkg::S_DISPATCH : gle_pkg::S_START;
        end
      end
      gle_pkg::S_START: begin
        cw.valid = 1'b1;
        cw.code  = clear_code[CW-1:0];
        cw.width = width;
        if (code_ready) begin
          started_next = 1'b1;
          state_next   = gle_pkg::S_DISPATCH;
        end
      end
      gle_pkg::S_DISPATCH: begin
        if (!have_prefix) begin
          cur_next         = CW'(p);
          have_prefix_next = 1'b1;
          state_next       = gle_pkg::S_TAIL;
        end else begin
          state_next = gle_pkg::S_CHILD;
        end
      end
      gle_pkg::S_CHILD: begin
        head_next  = first;
        ptr_next   = first;
        state_next = (first == '0) ? gle_pkg::S_MISS : gle_pkg::S_NODE;
      end
      gle_pkg::S_NODE: begin
        if (pix == p) begin
          cur_next   = ptr;
          state_next = gle_pkg::S_TAIL;
        end else if (sib == '0) begin
          state_next = gle_pkg::S_MISS;
        end else begin
          ptr_next = sib;
          node_ra  = sib;
        end
      end
      gle_pkg::S_MISS: begin
        cw.valid = 1'b1;
        cw.code  = cur;
        cw.width = width;
        if (code_ready) begin
          width_next = grown;
          state_next = gle_pkg::S_INS_A;
        end
      end
      gle_pkg::S_INS_A: begin
        // Link the new code at the head of the prefix's child list.
        node_we    = 1'b1;
        child_we   = 1'b1;
        set_wr     = 1'b1;
        state_next = gle_pkg::S_INS_B;
      end
      gle_pkg::S_INS_B: begin
        child_we       = 1'b1;
        child_wa       = next_code[CW-1:0];
        child_wd       = '0;
        set_wr         = 1'b1;
        set_addr       = next_code[CW-1:0];
        next_code_next = next_code + 1'b1;
        if (next_code + 1'b1 >= NW'(gle_pkg::CODE_LIMIT)) begin
          state_next = gle_pkg::S_RESTART;
        end else begin
          cur_next   = CW'(p);
          state_next = gle_pkg::S_TAIL;
        end
      end
      gle_pkg::S_RESTART: begin
        cw.valid = 1'b1;
        cw.code  = clear_code[CW-1:0];
        cw.width = width;
        if (code_ready) begin
          width_next     = root + 1'b1;
          next_code_next = clear_code + NW'(2);
          wr_clear       = 1'b1;
          cur_next       = CW'(p);
          state_next     = gle_pkg::S_TAIL;
        end
      end
      gle_pkg::S_TAIL: begin
        state_next = last ? gle_pkg::S_FIN_PREFIX : gle_pkg::S_IDLE;
      end
      gle_pkg::S_FIN_PREFIX: begin
        cw.valid = 1'b1;
        cw.code  = cur;
        cw.width = width;
        if (code_ready) begin
          width_next = grown;
          state_next = gle_pkg::S_FIN_EOI;
        end
      end
      gle_pkg::S_FIN_EOI: begin
        cw.valid = 1'b1;
        cw.code  = clear_code[CW-1:0] + 1'b1;
        cw.width = width;
        cw.eoi   = 1'b1;
        if (code_ready) begin
          have_prefix_next = 1'b0;
          started_next     = 1'b0;
          cur_next         = '0;
          width_next       = root + 1'b1;
          next_code_next   = clear_code + NW'(2);
          wr_clear         = 1'b1;
          state_next       = gle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gle_pkg::S_IDLE;
      end
    endcase
  end

  `GLE_CHECK(a_width_range, clr, cw.valid,
             cw.width <= RW'(gle_pkg::MAX_CODE_BITS) && cw.width > root)
  `GLE_CHECK(a_code_fits, clr, cw.valid, {1'b0, cw.code} < (NW'(1) << cw.width))
  `GLE_CHECK(a_insert_in_table, clr, state == gle_pkg::S_INS_B,
             next_code < NW'(gle_pkg::CODE_LIMIT))
  `GLE_CHECK_NEXT(a_code_holds, clr, cw.valid && !code_ready,
                  cw.valid && $stable(cw.code) && $stable(cw.width))

endmodule

`default_nettype wire

### hw/rtl/gle_packer.sv
// ---------------------------------------------------------------------------
// GIF LZW encoder bit packer
// Packs codes LSB first into bytes and queues them for the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module gle_packer (
  input  wire logic                   clk,
  input  wire logic                   clr,
  input  gle_pkg::code_word_t         cw,
  output logic                        code_ready,
  input  wire logic                   pop,
  output logic                        empty,
  output logic [gle_pkg::PIX_W-1:0]   out_byte,
  output logic                        last_byte
);

  localparam int AW = gle_pkg::ACC_W;
  localparam int NW = gle_pkg::ACC_CNT_W;
  localparam int CW = gle_pkg::CODE_W;
  localparam int PW = $clog2(gle_pkg::OUT_DEPTH);

  logic [AW-1:0] acc;
  logic [NW-1:0] acc_n;
  logic          flush;
  logic [8:0]    mem [gle_pkg::OUT_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          fifo_full;
  logic          emit;
  logic          emit_last;
  logic          accept;
  logic          rd;
  logic [CW-1:0] masked;

  assign fifo_full  = (cnt == (PW+1)'(gle_pkg::OUT_DEPTH));
  assign code_ready = (acc_n < NW'(8)) && !flush;
  assign accept     = cw.valid && code_ready;
  assign emit       = (acc_n >= NW'(8) || (flush && acc_n != '0)) && !fifo_full;
  assign emit_last  = flush && (acc_n <= NW'(8));
  assign masked     = cw.code & ~({CW{1'b1}} << cw.width);
  assign rd         = pop && (cnt != '0);

  assign empty     = (cnt == '0);
  assign out_byte  = mem[rp][7:0];
  assign last_byte = mem[rp][8];

  always_ff @(posedge clk) begin
    if (emit) begin
      mem[wp] <= {emit_last, acc[7:0]};
    end
    if (clr) begin
      acc   <= '0;
      acc_n <= '0;
      flush <= 1'b0;
      wp    <= '0;
      rp    <= '0;
      cnt   <= '0;
    end else begin
      if (accept) begin
        acc   <= acc | (AW'(masked) << acc_n);
        acc_n <= acc_n + NW'(cw.width);
        flush <= cw.eoi;
      end else if (emit) begin
        // Drop the sent byte; a padded tail byte empties the buffer.
        acc   <= acc >> 8;
        acc_n <= (acc_n >= NW'(8)) ? acc_n - NW'(8) : '0;
        if (emit_last) flush <= 1'b0;
      end
      if (emit) wp <= wp + 1'b1;
      if (rd)   rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(emit) - (PW+1)'(rd);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gif_lzw_encoder.sv
// Codes: a miss hands its prefix code to the packer, and a miss that fills the table
// also sends a clear code and restarts the dictionary; a hit gives no byte.
// Pixels: the engine takes a new pixel only once it is through with the last one;
// packer and output queue back-pressure add stalls.
// Reset: rst (synchronous, active high) and every root_bits write restart the
// encoder; no clearing pass, per-root link valid bits clear with the restart.
// ---------------------------------------------------------------------------
// GIF LZW encoder top level
// Pixel queue feeds the dictionary engine, which hands codes to the bit packer and its output queue.
// ---------------------------------------------------------------------------
`default_nettype none

module gif_lzw_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // pixel word channel
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] pixel,
  input  wire logic       last_pixel,
  // code byte channel
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last_byte,
  // root_bits write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);

  logic [gle_pkg::ROOT_W-1:0] root_bits;
  logic [gle_pkg::ROOT_W-1:0] root;
  logic [gle_pkg::ROOT_W-1:0] root_load;
  logic                       cfg_wr;
  logic                       clr;
  gle_pkg::pix_word_t         pix_word;
  logic                       take;
  gle_pkg::code_word_t        code_word;
  logic                       code_ready;

  // Writes are taken at once; the user must write only while the block is idle, and the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // A register write restarts the whole encoder, like reset.
  assign clr       = rst || cfg_wr;
  assign root      = gle_pkg::eff_root(root_bits);
  // Root width that the restart loads: reset value or the word being written.
  assign root_load = rst ? gle_pkg::ROOT_W'(gle_pkg::ROOT_RESET) : gle_pkg::eff_root(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_bits <= gle_pkg::ROOT_W'(gle_pkg::ROOT_RESET);
    end else if (cfg_wr) begin
      root_bits <= cfg_data;
    end
  end

  // Front: queue pixels masked to the root width.
  gle_front u_front (
    .clk(clk), .clr(clr), .root(root),
    .push(push), .full(full), .pixel(pixel), .last_pixel(last_pixel),
    .word(pix_word), .take(take)
  );

  // Back: trie walk, insert, clear and end codes.
  gle_back u_back (
    .clk(clk), .clr(clr), .root(root), .root_load(root_load),
    .in_word(pix_word), .take(take),
    .cw(code_word), .code_ready(code_ready)
  );

  // Packer: LSB-first bytes into the output queue.
  gle_packer u_packer (
    .clk(clk), .clr(clr), .cw(code_word), .code_ready(code_ready),
    .pop(pop), .empty(empty), .out_byte(out_byte), .last_byte(last_byte)
  );

endmodule

`default_nettype wire

### dv/gif_lzw_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GIF LZW encoder testbench
// Feeds pixel words, with directed rows first and random images after them,
// over several root_bits settings. Every code byte that leaves the block is
// compared with the expected stream: typed bytes for plain directed rows, else
// the bytes that a behavioral encoder inside this bench builds for the same pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module gif_lzw_encoder_tb;

  localparam int WATCHDOG   = 5000;
  localparam int DRAIN_WAIT = 1500;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } code_byte_t;

  // one directed row: the pixel word and, where it is plain, the bytes it gives
  typedef struct {
    logic [7:0] pix;
    logic       fin;
    int         n_typed;
    logic [7:0] typed [2];
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] pixel = '0;
  logic       last_pixel = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;

  // expected code bytes, oldest first
  code_byte_t exp_bytes[$];
  int         n_errors = 0;
  bit         calm = 1'b0;   // no idling on either side while set
  int         quiet_cycles = 0;

  // behavioral encoder state
  logic [3:0]  root_reg;
  bit   [19:0] str_tab [gle_pkg::TABLE_SIZE];
  int          code_of [bit [19:0]];
  int          cur_code;
  bit          have_prefix;
  bit          started;
  int          nxt_code;
  int          code_width;
  logic [31:0] acc;
  int          acc_n;

  gif_lzw_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .last_pixel(last_pixel),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_root();
    int r;
    r = root_reg;
    if (r < gle_pkg::ROOT_MIN) r = gle_pkg::ROOT_MIN;
    if (r > gle_pkg::ROOT_MAX) r = gle_pkg::ROOT_MAX;
    return r;
  endfunction

  function automatic void restart_dict();
    code_width = clamp_root() + 1;
    nxt_code   = (1 << clamp_root()) + 2;
  endfunction

  function automatic void restart_encoder();
    foreach (str_tab[i]) str_tab[i] = '0;
    code_of.delete();
    cur_code    = 0;
    have_prefix = 1'b0;
    started     = 1'b0;
    acc         = '0;
    acc_n       = 0;
    restart_dict();
  endfunction

  // Append a code to the bit stream, LSB first, and release whole bytes.
  function automatic void pack_code(int code, int w);
    acc   = acc | ((32'(code) & ((32'd1 << w) - 1)) << acc_n);
    acc_n = acc_n + w;
    while (acc_n >= 8) begin
      exp_bytes.push_back('{data: acc[7:0], fin: 1'b0});
      acc   = acc >> 8;
      acc_n = acc_n - 8;
    end
  endfunction

  function automatic void widen_if_due();
    if (code_width < gle_pkg::MAX_CODE_BITS && nxt_code == (1 << code_width))
      code_width++;
  endfunction

  // Encode one pixel word and queue the bytes it releases.
  function automatic void encode_pixel(logic [7:0] pix, logic fin);
    int         clr;
    int         p;
    int         k;
    bit         hit;
    bit [19:0]  key;
    code_byte_t tail;
    clr = 1 << clamp_root();
    p   = pix & (clr - 1);
    if (!started) begin
      pack_code(clr, code_width);
      started = 1'b1;
    end
    if (!have_prefix) begin
      cur_code    = p;
      have_prefix = 1'b1;
    end else begin
      hit = 1'b0;
      key = {cur_code[11:0], p[7:0]};
      if (code_of.exists(key)) begin
        k = code_of[key];
        if (k >= clr + 2 && k < nxt_code && k < gle_pkg::TABLE_SIZE && str_tab[k] == key) begin
          cur_code = k;
          hit      = 1'b1;
        end
      end
      if (!hit) begin
        // miss: send the prefix, grow, then add the new string
        pack_code(cur_code, code_width);
        widen_if_due();
        if (nxt_code < gle_pkg::TABLE_SIZE) begin
          str_tab[nxt_code] = key;
          code_of[key]      = nxt_code;
        end
        nxt_code++;
        if (nxt_code >= gle_pkg::CODE_LIMIT) begin
          pack_code(clr, code_width);
          restart_dict();
        end
        cur_code = p;
      end
    end
    if (fin) begin
      // flush the prefix, then EOI, and pad the final byte with zeros
      pack_code(cur_code, code_width);
      widen_if_due();
      pack_code(clr + 1, code_width);
      if (acc_n > 0) pack_code(0, 8 - acc_n);
      tail     = exp_bytes.pop_back();
      tail.fin = 1'b1;
      exp_bytes.push_back(tail);
      restart_encoder();
    end
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  // Drive one pixel word and hold it until the block takes it.
  task automatic send_pixel(logic [7:0] pix, logic fin);
    while (idle_now()) begin
      push = 1'b0;
      @(negedge clk);
    end
    push       = 1'b1;
    pixel      = pix;
    last_pixel = fin;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
  endtask

  // Wait for every expected byte, then for the longest trie walks still queued.
  task automatic drain();
    while (exp_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_root(logic [3:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    root_reg  = v;
    restart_encoder();
  endtask

  // Random pixel, usually inside the alphabet, sometimes with junk high bits.
  function automatic logic [7:0] rand_pixel();
    int mask;
    mask = (1 << clamp_root()) - 1;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 1) * mask);
    return 8'($urandom_range(0, mask));
  endfunction

  // Result side: pop at random and check each word taken.
  always @(negedge clk) begin
    pop <= !rst && (calm || $urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    code_byte_t want;
    if (!rst && pop && !empty) begin
      if (exp_bytes.size() == 0) begin
        $error("unexpected code byte %02h", out_byte);
        n_errors++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %02h actual %02h", want.data, out_byte);
          n_errors++;
        end
        if (last_byte !== want.fin) begin
          $error("last_byte expected %0b actual %0b", want.fin, last_byte);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    logic [3:0]  roots[$];
    int          len;
    logic [7:0]  p;
    root_reg = 4'(gle_pkg::ROOT_RESET);
    restart_encoder();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows at the reset width: one-pixel images, repeats that hit
    // the dictionary, the top pixel, junk high bits, an immediate end.
    rows.push_back('{8'h03, 1'b1, 2, '{8'h5C, 8'h01}});
    rows.push_back('{8'hFC, 1'b1, 2, '{8'h44, 8'h01}});
    for (int i = 0; i < 6; i++) rows.push_back('{8'h00, 1'b0, 0, '{8'h0, 8'h0}});
    rows.push_back('{8'h00, 1'b1, 0, '{8'h0, 8'h0}});
    for (int i = 0; i < 8; i++) rows.push_back('{8'(i), 1'b0, 0, '{8'h0, 8'h0}});
    rows.push_back('{8'hFF, 1'b0, 0, '{8'h0, 8'h0}});
    rows.push_back('{8'hAA, 1'b0, 0, '{8'h0, 8'h0}});
    rows.push_back('{8'h55, 1'b0, 0, '{8'h0, 8'h0}});
    rows.push_back('{8'hFF, 1'b1, 0, '{8'h0, 8'h0}});
    foreach (rows[i]) begin
      if (rows[i].n_typed > 0) begin
        // plain one-pixel image: clear, pixel, EOI at three bits
        for (int j = 0; j < rows[i].n_typed; j++)
          exp_bytes.push_back('{data: rows[i].typed[j], fin: (j == rows[i].n_typed - 1)});
        restart_encoder();
      end else begin
        encode_pixel(rows[i].pix, rows[i].fin);
      end
      send_pixel(rows[i].pix, rows[i].fin);
    end

    // Random images over a sweep of settings, out-of-range ones included.
    // A phase may end mid-image: the write then drops the pending bits.
    roots = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd1, 4'd4, 4'd9, 4'd3, 4'd7, 4'd5, 4'd6, 4'd8};
    foreach (roots[r]) begin
      write_root(roots[r]);
      calm = (r == 5);
      for (int n = 0; n < 18; n++) begin
        p = rand_pixel();
        send_pixel(p, 1'b0);
        encode_pixel(p, 1'b0);
        if ($urandom_range(0, 9) == 0) begin
          send_pixel(p, 1'b1);
          encode_pixel(p, 1'b1);
        end
      end
    end
    calm = 1'b0;

    // One longer image at two bits: grow the code width a few times, then
    // close it.
    write_root(4'd2);
    len = 60;
    for (int n = 0; n < len; n++) begin
      p = 8'($urandom_range(0, 3));
      send_pixel(p, n == len - 1);
      encode_pixel(p, n == len - 1);
    end

    drain();
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### gif_lzw_encoder.f
+incdir+hw/rtl
hw/rtl/gle_pkg.sv
hw/rtl/gle_ram.sv
hw/rtl/gle_front.sv
hw/rtl/gle_back.sv
hw/rtl/gle_packer.sv
hw/rtl/gif_lzw_encoder.sv
dv/gif_lzw_encoder_tb.sv
